FILE: src/mfe_pkg.sv
// Shared types and constants for the metaball field evaluator.
`timescale 1ns / 1ps

package mfe_pkg;

  localparam int GRID_SIZE_DEF   = 32;
  localparam int MAX_SPHERES_DEF = 32;

  localparam int COORD_W = 16;            // Q2.14 centre coordinate
  localparam int GRID_W  = 5;             // grid index
  localparam int IDX_W   = 5;             // sphere_index field
  localparam int CNT_W   = 6;             // sphere_count register
  localparam int FIELD_W = 32;            // Q12.20 field value
  localparam int ONE_Q14 = 16384;
  localparam int D_W     = 27;            // signed difference, |D| < 2^25
  localparam int MAG_W   = D_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int S_W     = SQ_W + 2;      // sum of three squares
  localparam int Q_W     = 32;            // quotient bits produced
  localparam int REM_W   = S_W + 1;
  // Below or at this distance squared the reciprocal exceeds the field range.
  localparam int SAT_LIMIT = 262144;      // 2^18 = 2^50 >> 32

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_ADDSQ,
    ST_DIVIDE,
    ST_ACCUM,
    ST_DONE
  } mfe_state_t;

endpackage

FILE: src/metaball_field_evaluator_core.sv
// Metaball field evaluator: sphere table memory and per-sphere sequencer.
// An evaluate, once accepted, walks the N summed spheres in turn: per sphere a
// memory read, a difference, 3 square and 3 accumulate steps, 32 steps of the shared
// restoring divider (skipped when the term clamps) and an add, then presents its result.
// Throughput: one request at a time; the divider loop sets the rate.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// sphere_count; the sphere table is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module metaball_field_evaluator_core
  import mfe_pkg::*;
#(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CNT_W-1:0]    cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [4:0] sphere_index, [20:5] centre_x, [36:21] centre_y, [52:37] centre_z,
  // [57:53] grid_x, [62:58] grid_y, [67:63] grid_z, [71:68] zero
  input  logic [71:0]         in_tdata,
  // [0] command
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [31:0] field_value
  output logic [FIELD_W-1:0]  out_tdata,
  // [0] saturated
  output logic                out_tuser
);

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);
  localparam int QC_W = $clog2(Q_W);

  logic [3*COORD_W-1:0] mem [MAX_SPHERES];
  logic [3*COORD_W-1:0] rd_data_r;

  mfe_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cfg_count_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [GRID_W-1:0]  gx_r, gy_r, gz_r, gx_nxt, gy_nxt, gz_nxt;
  logic [MAG_W-1:0]   mag_r [3];
  logic [MAG_W-1:0]   mag_nxt [3];
  logic [1:0]         axis_r, axis_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [S_W-1:0]     s_r, s_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [QC_W-1:0]    qc_r, qc_nxt;
  logic               term_sat_r, term_sat_nxt;
  logic [FIELD_W-1:0] sum_r, sum_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r, out_data_nxt;
  logic               out_sat_r, out_sat_nxt;

  logic               in_acc;
  logic [IDX_W-1:0]   ld_idx;
  logic               ld_ok;
  logic [AW-1:0]      rd_addr;
  logic [REM_W-1:0]   rem_sh;
  logic [FIELD_W:0]   sum_ext;
  logic [FIELD_W-1:0] term;
  logic [8:0]         cfg_wide;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign ld_idx     = in_tdata[4:0];
  assign ld_ok      = ({4'b0, ld_idx} < 9'(MAX_SPHERES));
  assign rd_addr    = n_r[AW-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign cfg_wide   = {3'b0, cfg_count_r};

  // Table write on a load request, registered read for the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == CMD_LOAD && ld_ok) begin
      mem[AW'(ld_idx)] <= in_tdata[52:5];
    end
    rd_data_r <= mem[rd_addr];
  end

  function automatic logic [MAG_W-1:0] abs_diff(input logic [GRID_W-1:0] g,
                                                input logic [COORD_W-1:0] c);
    logic signed [D_W-1:0] pos;
    logic signed [D_W-1:0] gp;
    logic signed [D_W-1:0] d;
    pos = D_W'((D_W'(signed'(c)) + D_W'(ONE_Q14)) * D_W'(GRID_SIZE));
    gp  = signed'({{(D_W-GRID_W-15){1'b0}}, g, 15'b0});
    d   = gp - pos;
    abs_diff = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    n_r        <= n_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    gz_r       <= gz_nxt;
    mag_r      <= mag_nxt;
    axis_r     <= axis_nxt;
    sq_r       <= sq_nxt;
    s_r        <= s_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    qc_r       <= qc_nxt;
    term_sat_r <= term_sat_nxt;
    sum_r      <= sum_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    gz_nxt        = gz_r;
    mag_nxt       = mag_r;
    axis_nxt      = axis_r;
    sq_nxt        = sq_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    qc_nxt        = qc_r;
    term_sat_nxt  = term_sat_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    rem_sh        = {rem_r[REM_W-2:0], 1'b0};
    term          = term_sat_r ? '1 : q_r;
    sum_ext       = {1'b0, sum_r} + {1'b0, term};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == CMD_EVAL) begin
          gx_nxt  = in_tdata[57:53];
          gy_nxt  = in_tdata[62:58];
          gz_nxt  = in_tdata[67:63];
          count_nxt = (cfg_wide > 9'(MAX_SPHERES)) ? CW'(MAX_SPHERES) : CW'(cfg_count_r);
          n_nxt   = '0;
          sum_nxt = '0;
          sat_nxt = 1'b0;
          state_nxt = (cfg_count_r == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        mag_nxt[0] = abs_diff(gx_r, rd_data_r[15:0]);
        mag_nxt[1] = abs_diff(gy_r, rd_data_r[31:16]);
        mag_nxt[2] = abs_diff(gz_r, rd_data_r[47:32]);
        axis_nxt   = '0;
        s_nxt      = '0;
        state_nxt  = ST_SQUARE;
      end
      ST_SQUARE: begin
        sq_nxt    = mag_r[axis_r] * mag_r[axis_r];
        state_nxt = ST_ADDSQ;
      end
      ST_ADDSQ: begin
        s_nxt = s_r + S_W'(sq_r);
        if (axis_r == 2'd2) begin
          // Zero distance or a reciprocal beyond the field range clamps the term.
          if (s_nxt <= S_W'(SAT_LIMIT)) begin
            term_sat_nxt = 1'b1;
            state_nxt    = ST_ACCUM;
          end else begin
            term_sat_nxt = 1'b0;
            rem_nxt      = REM_W'(SAT_LIMIT);
            q_nxt        = '0;
            qc_nxt       = '0;
            state_nxt    = ST_DIVIDE;
          end
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_DIVIDE: begin
        if (rem_sh >= REM_W'(s_r)) begin
          rem_nxt = rem_sh - REM_W'(s_r);
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
        qc_nxt = qc_r + 1'b1;
        if (qc_r == QC_W'(Q_W - 1)) begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (sum_ext[FIELD_W]) begin
          sum_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[FIELD_W-1:0];
          sat_nxt = sat_r | term_sat_r;
        end
        n_nxt     = n_r + 1'b1;
        state_nxt = (n_r + 1'b1 == count_r) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE |-> s_r > S_W'(SAT_LIMIT))
    else $error("divider running on a distance that should have clamped");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> n_r < count_r)
    else $error("sphere counter ran past the count");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !(out_valid_r && !out_tready) |=> out_valid_r)
    else $error("finished evaluate did not present a result");

endmodule
